### rtl/core/imrot_pkg.sv
`timescale 1ns / 1ps

package imrot_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int SRC_DIM_W  = 11;
    localparam int DST_DIM_W  = 12;
    localparam int COORD_W    = 11;
    localparam int COEF_W     = 16;
    localparam int CTR_W      = 12;
    localparam int PROD_W     = 28;
    localparam int SUM_W      = 29;
    localparam int ROT_W      = SUM_W - FRAC_BITS;
    localparam int OFS_W      = 16;
    localparam int SIDX_W     = 20;
    localparam int DIDX_W     = 22;
    localparam int SPROD_W    = 2 * SRC_DIM_W;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [COEF_W-1:0] COS_RESET = COEF_W'(1 << FRAC_BITS);

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_COS_ANGLE  = 3'd4,
        REG_SIN_ANGLE  = 3'd5
    } t_reg_idx;

endpackage

### rtl/core/image_rotate_address_map_top.sv
// throughput: one item per cycle; each stage holds while the next is full and stalled
// stages: center, multiply, sum and truncate, bound check, index multiply, index add
// reset: synchronous active-low i_rst_n clears all stage valid bits and loads
// the configuration registers with their defaults (1x1 frames, zero angle)
`timescale 1ns / 1ps

module image_rotate_address_map_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imrot_pkg::ADDR_W-1:0]      paddr,
    input  logic [imrot_pkg::DATA_W-1:0]      pwdata,
    output logic [imrot_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [imrot_pkg::COORD_W-1:0]     i_dst_col,
    input  logic [imrot_pkg::COORD_W-1:0]     i_dst_row,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [imrot_pkg::SIDX_W-1:0]      o_src_index,
    output logic [imrot_pkg::DIDX_W-1:0]      o_dst_index,
    output logic                              o_hit
);

    // configuration registers
    logic [imrot_pkg::SRC_DIM_W-1:0]        r_src_width, r_src_height;
    logic [imrot_pkg::DST_DIM_W-1:0]        r_dst_width, r_dst_height;
    logic signed [imrot_pkg::COEF_W-1:0]    r_cos_angle, r_sin_angle;
    logic                                   w_wr;
    imrot_pkg::t_reg_idx                    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = imrot_pkg::t_reg_idx'(paddr[imrot_pkg::ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= imrot_pkg::SRC_DIM_W'(1);
            r_src_height <= imrot_pkg::SRC_DIM_W'(1);
            r_dst_width  <= imrot_pkg::DST_DIM_W'(1);
            r_dst_height <= imrot_pkg::DST_DIM_W'(1);
            r_cos_angle  <= imrot_pkg::COS_RESET;
            r_sin_angle  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                imrot_pkg::REG_SRC_WIDTH:  r_src_width  <= pwdata[imrot_pkg::SRC_DIM_W-1:0];
                imrot_pkg::REG_SRC_HEIGHT: r_src_height <= pwdata[imrot_pkg::SRC_DIM_W-1:0];
                imrot_pkg::REG_DST_WIDTH:  r_dst_width  <= pwdata[imrot_pkg::DST_DIM_W-1:0];
                imrot_pkg::REG_DST_HEIGHT: r_dst_height <= pwdata[imrot_pkg::DST_DIM_W-1:0];
                imrot_pkg::REG_COS_ANGLE:  r_cos_angle  <= pwdata[imrot_pkg::COEF_W-1:0];
                imrot_pkg::REG_SIN_ANGLE:  r_sin_angle  <= pwdata[imrot_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            imrot_pkg::REG_SRC_WIDTH:  prdata = imrot_pkg::DATA_W'(r_src_width);
            imrot_pkg::REG_SRC_HEIGHT: prdata = imrot_pkg::DATA_W'(r_src_height);
            imrot_pkg::REG_DST_WIDTH:  prdata = imrot_pkg::DATA_W'(r_dst_width);
            imrot_pkg::REG_DST_HEIGHT: prdata = imrot_pkg::DATA_W'(r_dst_height);
            imrot_pkg::REG_COS_ANGLE:  prdata = imrot_pkg::DATA_W'(r_cos_angle);
            imrot_pkg::REG_SIN_ANGLE:  prdata = imrot_pkg::DATA_W'(r_sin_angle);
            default:                   prdata = '0;
        endcase
    end

    // stage valid bits and per-stage load enables
    logic [6:1] r_v;
    logic [6:1] w_en;

    assign w_en[6] = ~r_v[6] | i_ready;
    assign w_en[5] = ~r_v[5] | w_en[6];
    assign w_en[4] = ~r_v[4] | w_en[5];
    assign w_en[3] = ~r_v[3] | w_en[4];
    assign w_en[2] = ~r_v[2] | w_en[3];
    assign w_en[1] = ~r_v[1] | w_en[2];
    assign o_ready = w_en[1];
    assign o_valid = r_v[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= i_valid;
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
            if (w_en[4]) r_v[4] <= r_v[3];
            if (w_en[5]) r_v[5] <= r_v[4];
            if (w_en[6]) r_v[6] <= r_v[5];
        end
    end

    // stage 1: center on destination frame
    logic signed [imrot_pkg::CTR_W-1:0]     r1_xc, r1_yc;
    logic signed [imrot_pkg::DST_DIM_W:0]   r1_drow;
    logic [imrot_pkg::COORD_W-1:0]          r1_col;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_xc   <= $signed({1'b0, i_dst_col}) - $signed({1'b0, r_dst_width[11:1]});
            r1_yc   <= $signed({1'b0, i_dst_row}) - $signed({1'b0, r_dst_height[11:1]});
            r1_drow <= $signed({1'b0, r_dst_height}) - $signed({2'b0, i_dst_row})
                       - $signed(13'sd1);
            r1_col  <= i_dst_col;
        end
    end

    // stage 2: rotation products and destination row product
    logic signed [imrot_pkg::PROD_W-1:0]    r2_xcos, r2_ysin, r2_xsin, r2_ycos;
    logic signed [2*imrot_pkg::DST_DIM_W+1:0] w2_dprod;
    logic [imrot_pkg::DIDX_W-1:0]           r2_dprod;
    logic [imrot_pkg::COORD_W-1:0]          r2_col;

    assign w2_dprod = r1_drow * $signed({1'b0, r_dst_width});

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_xcos  <= r1_xc * r_cos_angle;
            r2_ysin  <= r1_yc * r_sin_angle;
            r2_xsin  <= r1_xc * r_sin_angle;
            r2_ycos  <= r1_yc * r_cos_angle;
            r2_dprod <= w2_dprod[imrot_pkg::DIDX_W-1:0];
            r2_col   <= r1_col;
        end
    end

    // stage 3: sums, truncation toward zero, destination index
    logic signed [imrot_pkg::SUM_W-1:0]     w3_sx, w3_sy, w3_bx, w3_by;
    logic signed [imrot_pkg::ROT_W-1:0]     r3_x, r3_y;
    logic [imrot_pkg::DIDX_W-1:0]           r3_didx;

    assign w3_sx = r2_xcos - r2_ysin;
    assign w3_sy = r2_xsin + r2_ycos;
    assign w3_bx = w3_sx + (w3_sx[imrot_pkg::SUM_W-1] ? imrot_pkg::ROUND_BIAS : '0);
    assign w3_by = w3_sy + (w3_sy[imrot_pkg::SUM_W-1] ? imrot_pkg::ROUND_BIAS : '0);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_x    <= w3_bx[imrot_pkg::SUM_W-1:imrot_pkg::FRAC_BITS];
            r3_y    <= w3_by[imrot_pkg::SUM_W-1:imrot_pkg::FRAC_BITS];
            r3_didx <= r2_dprod + imrot_pkg::DIDX_W'(r2_col);
        end
    end

    // stage 4: bound check against centered source
    logic signed [imrot_pkg::OFS_W-1:0]     w4_ux, w4_uy, w4_rt;
    logic                                   w4_hit;
    logic [imrot_pkg::SRC_DIM_W-1:0]        r4_ux, r4_rt;
    logic                                   r4_hit;
    logic [imrot_pkg::DIDX_W-1:0]           r4_didx;

    assign w4_ux = $signed({r3_x[imrot_pkg::ROT_W-1], r3_x})
                   + $signed({6'b0, r_src_width[10:1]});
    assign w4_uy = $signed({r3_y[imrot_pkg::ROT_W-1], r3_y})
                   + $signed({6'b0, r_src_height[10:1]});
    assign w4_rt = $signed({5'b0, r_src_height}) - $signed(16'sd1) - w4_uy;
    assign w4_hit = ~w4_ux[imrot_pkg::OFS_W-1]
                    & (w4_ux[imrot_pkg::OFS_W-2:0] < 15'(r_src_width))
                    & ~w4_uy[imrot_pkg::OFS_W-1]
                    & (w4_uy[imrot_pkg::OFS_W-2:0] < 15'(r_src_height));

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_ux   <= w4_ux[imrot_pkg::SRC_DIM_W-1:0];
            r4_rt   <= w4_rt[imrot_pkg::SRC_DIM_W-1:0];
            r4_hit  <= w4_hit;
            r4_didx <= r3_didx;
        end
    end

    // stage 5: source row product
    logic [imrot_pkg::SPROD_W-1:0]          r5_sprod;
    logic [imrot_pkg::SRC_DIM_W-1:0]        r5_ux;
    logic                                   r5_hit;
    logic [imrot_pkg::DIDX_W-1:0]           r5_didx;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_sprod <= r4_rt * r_src_width;
            r5_ux    <= r4_ux;
            r5_hit   <= r4_hit;
            r5_didx  <= r4_didx;
        end
    end

    // stage 6: source index and output register
    logic [imrot_pkg::SPROD_W-1:0]          w6_sidx;
    logic [imrot_pkg::SIDX_W-1:0]           r6_sidx;
    logic                                   r6_hit;
    logic [imrot_pkg::DIDX_W-1:0]           r6_didx;

    assign w6_sidx = r5_sprod + imrot_pkg::SPROD_W'(r5_ux);

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_sidx <= r5_hit ? w6_sidx[imrot_pkg::SIDX_W-1:0] : '0;
            r6_hit  <= r5_hit;
            r6_didx <= r5_didx;
        end
    end

    assign o_src_index = r6_sidx;
    assign o_dst_index = r6_didx;
    assign o_hit       = r6_hit;

`ifndef ASSERT_OFF
    a_miss_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_src_index == '0)
        else $error("missed item carries a nonzero source index");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v[1])
        else $error("accepted item not held in first stage");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[2] |-> o_ready)
        else $error("input stalled with an empty second stage");
`endif

endmodule

### tb/sv/image_rotate_address_map_top_tb.sv
`timescale 1ns / 1ps

module image_rotate_address_map_top_tb;
    import imrot_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_STALL     = 300;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [SIDX_W-1:0] src_index;
        logic [DIDX_W-1:0] dst_index;
        logic              hit;
    } address_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_W-1:0]    paddr       = '0;
    logic [DATA_W-1:0]    pwdata      = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [COORD_W-1:0]   i_dst_col   = '0;
    logic [COORD_W-1:0]   i_dst_row   = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [SIDX_W-1:0]    o_src_index;
    logic [DIDX_W-1:0]    o_dst_index;
    logic                 o_hit;

    // local copy of the register file
    logic [SRC_DIM_W-1:0]     cfg_src_w = 1;
    logic [SRC_DIM_W-1:0]     cfg_src_h = 1;
    logic [DST_DIM_W-1:0]     cfg_dst_w = 1;
    logic [DST_DIM_W-1:0]     cfg_dst_h = 1;
    logic signed [COEF_W-1:0] cfg_cos   = COS_RESET;
    logic signed [COEF_W-1:0] cfg_sin   = '0;

    pixel_t   coord_queue[$];
    address_t address_queue[$];

    int idle_pct    = 32;
    int stall_req   = 0;
    int stall_taken = 0;
    int stall_left  = 0;
    int err_cnt     = 0;
    int watchdog    = 0;

    always #5 i_clk = ~i_clk;

    image_rotate_address_map_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_dst_col   (i_dst_col),
        .i_dst_row   (i_dst_row),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_src_index (o_src_index),
        .o_dst_index (o_dst_index),
        .o_hit       (o_hit)
    );

    // inverse rotation of one destination pixel into source space
    function automatic address_t map_pixel(input logic [COORD_W-1:0] col,
                                           input logic [COORD_W-1:0] row);
        longint sw, sh, dw, dh, c, s;
        longint xc, yc, x, y, smx, smy;
        logic hit;
        address_t r;
        sw  = longint'(cfg_src_w);
        sh  = longint'(cfg_src_h);
        dw  = longint'(cfg_dst_w);
        dh  = longint'(cfg_dst_h);
        c   = longint'(cfg_cos);
        s   = longint'(cfg_sin);
        xc  = longint'(col) - dw / 2;
        yc  = longint'(row) - dh / 2;
        x   = (xc * c - yc * s) / (longint'(1) << FRAC_BITS);
        y   = (xc * s + yc * c) / (longint'(1) << FRAC_BITS);
        smx = -(sw / 2);
        smy = -(sh / 2);
        hit = (x >= smx) && (x < smx + sw) && (y >= smy) && (y < smy + sh);
        r.hit       = hit;
        r.src_index = hit ? SIDX_W'((sh - (y - smy) - 1) * sw + (x - smx)) : '0;
        r.dst_index = DIDX_W'((dh - longint'(row) - 1) * dw + longint'(col));
        return r;
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            flag_error($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
        end
    endtask

    // sender
    always @(posedge i_clk) begin : drive
        pixel_t nxt;
        logic   nxt_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_valid = i_valid && !o_ready;
            if (i_valid && o_ready) begin
                address_queue.push_back(map_pixel(i_dst_col, i_dst_row));
            end
            if (!nxt_valid && coord_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                nxt = coord_queue.pop_front();
                nxt_valid = 1'b1;
                i_dst_col <= nxt.col;
                i_dst_row <= nxt.row;
            end
            i_valid <= nxt_valid;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : collect
        address_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (address_queue.size() == 0) begin
                    flag_error($sformatf("unexpected item: src %0h dst %0h hit %0b",
                                         o_src_index, o_dst_index, o_hit));
                end else begin
                    want = address_queue.pop_front();
                    check_field("src_index", want.src_index, o_src_index);
                    check_field("dst_index", want.dst_index, o_dst_index);
                    check_field("hit", want.hit, o_hit);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else if (stall_taken != stall_req) begin
                stall_taken <= stall_taken + 1;
                stall_left <= LONG_STALL;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            watchdog <= 0;
        end else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input int width, input logic [31:0] value);
        logic [31:0] mask;
        mask = (32'h1 << width) - 1;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~mask) | (value & mask);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] sw, input logic [31:0] sh,
                             input logic [31:0] dw, input logic [31:0] dh,
                             input logic [31:0] c, input logic [31:0] s);
        write_reg(REG_SRC_WIDTH, SRC_DIM_W, sw);
        write_reg(REG_SRC_HEIGHT, SRC_DIM_W, sh);
        write_reg(REG_DST_WIDTH, DST_DIM_W, dw);
        write_reg(REG_DST_HEIGHT, DST_DIM_W, dh);
        write_reg(REG_COS_ANGLE, COEF_W, c);
        write_reg(REG_SIN_ANGLE, COEF_W, s);
        cfg_src_w = sw[SRC_DIM_W-1:0];
        cfg_src_h = sh[SRC_DIM_W-1:0];
        cfg_dst_w = dw[DST_DIM_W-1:0];
        cfg_dst_h = dh[DST_DIM_W-1:0];
        cfg_cos   = c[COEF_W-1:0];
        cfg_sin   = s[COEF_W-1:0];
    endtask

    task automatic random_config;
        int sw, sh, dw, dh, c, s, base;
        if ($urandom_range(99) < 20) begin
            sw = $urandom_range(2047);
            sh = $urandom_range(2047);
            dw = $urandom_range(4095);
            dh = $urandom_range(4095);
            c  = $urandom_range(65535);
            s  = $urandom_range(65535);
        end else begin
            sw   = $urandom_range(1024, 1);
            sh   = $urandom_range(1024, 1);
            base = (sw > sh) ? sw : sh;
            dw   = base + $urandom_range(base / 2);
            dh   = base + $urandom_range(base / 2);
            if (dw > 2048) dw = 2048;
            if (dh > 2048) dh = 2048;
            c = int'($urandom_range(32768)) - 16384;
            s = int'($urandom_range(32768)) - 16384;
        end
        configure(sw, sh, dw, dh, c, s);
    endtask

    task automatic add_item(input int col, input int row);
        pixel_t p;
        p.col = col[COORD_W-1:0];
        p.row = row[COORD_W-1:0];
        coord_queue.push_back(p);
    endtask

    // mostly pixels inside the destination frame, some anywhere
    task automatic add_random_items(input int n);
        int col_lim, row_lim;
        col_lim = (cfg_dst_w == 0) ? 0 : ((cfg_dst_w > 2048) ? 2047 : int'(cfg_dst_w) - 1);
        row_lim = (cfg_dst_h == 0) ? 0 : ((cfg_dst_h > 2048) ? 2047 : int'(cfg_dst_h) - 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 85) begin
                add_item($urandom_range(col_lim), $urandom_range(row_lim));
            end else begin
                add_item($urandom_range(2047), $urandom_range(2047));
            end
        end
    endtask

    // sampled after the clocked updates have settled
    task automatic wait_drained;
        do begin
            @(negedge i_clk);
        end while (coord_queue.size() != 0 || i_valid || address_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, destination index wraps for large coordinates
        add_item(0, 0);
        add_item(2047, 2047);
        add_item(0, 2047);
        add_item(2047, 0);
        add_item(1, 0);
        wait_drained;

        // identity rotation
        configure(1024, 1024, 1024, 1024, 16384, 0);
        add_item(0, 0);
        add_item(1023, 1023);
        add_item(512, 512);
        add_item(511, 511);
        add_item(1024, 0);
        wait_drained;

        // empty source
        configure(0, 5, 8, 8, 16384, 0);
        add_item(4, 4);
        add_item(1, 1);
        wait_drained;

        // full-scale coefficients, oversized source and destination
        configure(2047, 2047, 4095, 4095, 32'hFFFF_8000, 32'h0000_7FFF);
        add_item(0, 0);
        add_item(2047, 2047);
        add_item(2047, 0);
        wait_drained;

        // empty destination
        configure(16, 16, 0, 0, 16384, 0);
        add_item(0, 0);
        add_item(5, 7);
        wait_drained;

        // quarter turn
        configure(64, 32, 32, 64, 0, 16384);
        add_item(0, 0);
        add_item(31, 63);
        add_item(16, 32);
        wait_drained;

        // half turn
        configure(33, 17, 33, 17, 32'hFFFF_C000, 0);
        add_item(0, 0);
        add_item(32, 16);
        add_item(16, 8);
        wait_drained;

        for (int p = 0; p < 8; p++) begin
            random_config();
            idle_pct = (p == 4) ? 0 : 32;
            if (p == 2) begin
                stall_req++;
            end
            add_random_items((p == 4) ? 200 : 90);
            wait_drained;
        end
        idle_pct = 32;

        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
